>>> hw/rtl/i2ct_pkg.sv
// Package for the I2C register transfer sequencer.
// Holds opcodes, bus status codes, command classes and the queue entry type.
// No dependencies; every other file of the block but i2ct_ram imports it.
package i2ct_pkg;

  // Default number of bytes in the transfer buffer.
  localparam int unsigned BufferDepthDefault = 8;

  // Entries of the queue between the front and the back part.
  localparam int unsigned QueueDepth = 2;

  // Command opcodes as they arrive on the input channel.
  localparam logic [1:0] OpLoad  = 2'd0;
  localparam logic [1:0] OpStart = 2'd1;
  localparam logic [1:0] OpEvent = 2'd2;

  // Only the upper five bits of a status code are significant.
  localparam logic [7:0] StatusMask = 8'b1111_1000;

  // Bus status codes of the master controller.
  localparam logic [7:0] StStartSent     = 8'h08;
  localparam logic [7:0] StRepStartSent  = 8'h10;
  localparam logic [7:0] StAddrWrAck     = 8'h18;
  localparam logic [7:0] StAddrWrNack    = 8'h20;
  localparam logic [7:0] StDataTxAck     = 8'h28;
  localparam logic [7:0] StDataTxNack    = 8'h30;
  localparam logic [7:0] StArbLost       = 8'h38;
  localparam logic [7:0] StAddrRdAck     = 8'h40;
  localparam logic [7:0] StAddrRdNack    = 8'h48;
  localparam logic [7:0] StDataRxAck     = 8'h50;
  localparam logic [7:0] StDataRxNack    = 8'h58;

  // Kind of a command after decoding.
  typedef enum logic [1:0] {
    CmdLoad,
    CmdStart,
    CmdEvent,
    CmdNone
  } cmd_kind_e;

  // Class of a bus status event, which selects the next bus action.
  typedef enum logic [2:0] {
    ClsSendAddr,
    ClsSendAddrDir,
    ClsSendReg,
    ClsTxNext,
    ClsRxAddrAck,
    ClsRxData,
    ClsRxLast,
    ClsError
  } status_cls_e;

  // One decoded command as it travels through the queue.
  typedef struct packed {
    cmd_kind_e   kind;
    status_cls_e cls;
    logic        rnw;
    logic [7:0]  dev_addr;
    logic [7:0]  reg_idx;
    logic [3:0]  count;
    logic [2:0]  slot;
    logic [7:0]  data;
  } cmd_t;

endpackage

>>> hw/rtl/i2ct_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module i2ct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/i2ct_front.sv
// Front part of the I2C register transfer sequencer: accepts input beats
// and decodes opcode and bus status into a queue entry. Uses i2ct_pkg.
module i2ct_front import i2ct_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  logic       read_not_write_i,
  input  logic [7:0] device_address_i,
  input  logic [7:0] register_index_i,
  input  logic [3:0] byte_count_i,
  input  logic [2:0] buffer_slot_i,
  input  logic [7:0] load_value_i,
  input  logic [7:0] bus_status_i,
  input  logic [7:0] received_value_i,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic [7:0] status;

  // A beat is taken whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign status     = bus_status_i & StatusMask;

  // Decode the opcode and classify the status code.
  always_comb begin
    cmd_o          = '0;
    cmd_o.rnw      = read_not_write_i;
    cmd_o.dev_addr = device_address_i;
    cmd_o.reg_idx  = register_index_i;
    cmd_o.count    = byte_count_i;
    cmd_o.slot     = buffer_slot_i;
    cmd_o.data     = (opcode_i == OpLoad) ? load_value_i : received_value_i;

    case (opcode_i)
      OpLoad:  cmd_o.kind = CmdLoad;
      OpStart: cmd_o.kind = CmdStart;
      OpEvent: cmd_o.kind = CmdEvent;
      default: cmd_o.kind = CmdNone;
    endcase

    case (status)
      StStartSent:    cmd_o.cls = ClsSendAddr;
      StRepStartSent: cmd_o.cls = ClsSendAddrDir;
      StAddrWrAck:    cmd_o.cls = ClsSendReg;
      StDataTxAck:    cmd_o.cls = ClsTxNext;
      StAddrRdAck:    cmd_o.cls = ClsRxAddrAck;
      StDataRxAck:    cmd_o.cls = ClsRxData;
      StDataRxNack:   cmd_o.cls = ClsRxLast;
      StAddrWrNack,
      StDataTxNack,
      StArbLost,
      StAddrRdNack:   cmd_o.cls = ClsError;
      default:        cmd_o.cls = ClsError;
    endcase
  end

endmodule

>>> hw/rtl/i2ct_fifo.sv
// Short queue of decoded commands between the front and the back part.
// Uses i2ct_pkg for the entry type and the depth.
module i2ct_fifo import i2ct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue fill count beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into a full queue");

endmodule

>>> hw/rtl/i2ct_back.sv
// Back part of the I2C register transfer sequencer: transaction state,
// byte buffer and the registered result stage. Uses i2ct_pkg and i2ct_ram.
module i2ct_back import i2ct_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = BufferDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  cmd_t       cmd_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       issue_start_o,
  output logic       issue_stop_o,
  output logic       send_valid_o,
  output logic [7:0] byte_to_send_o,
  output logic       ack_next_o,
  output logic       rx_valid_o,
  output logic [2:0] rx_slot_o,
  output logic [7:0] rx_byte_o,
  output logic       done_ok_o,
  output logic       done_fail_o,
  output logic       busy_res_o
);

  localparam int unsigned IdxW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned CntW = (IdxW + 1 > 5) ? IdxW + 1 : 5;
  localparam logic [CntW-1:0] DepthCnt = CntW'(BUFFER_DEPTH);

  // Transaction state.
  logic            active_q, active_d;
  logic            dir_q, dir_d;
  logic [7:0]      addr_q, addr_d;
  logic [7:0]      ptr_q, ptr_d;
  logic [CntW-1:0] total_q, total_d;
  logic [CntW-1:0] prog_q, prog_d;

  // Buffer valid bits; an entry never written reads as zero.
  logic [BUFFER_DEPTH-1:0] vld_q;

  // Result stage.
  logic       out_vld_q;
  logic       start_q, stop_q, sendv_q, sel_ram_q, hit_q, ack_q;
  logic       rxv_q, ok_q, fail_q, busy_q;
  logic [7:0] send_byte_q, rx_byte_q;
  logic [2:0] rx_slot_q;

  // Next result values.
  logic       start_n, stop_n, sendv_n, sel_ram_n, ack_n, rxv_n, ok_n, fail_n;
  logic [7:0] send_byte_n;
  logic [2:0] rx_slot_n;

  // Buffer access.
  logic            we, re;
  logic [IdxW-1:0] waddr, raddr;
  logic [7:0]      wdata, rdata;

  logic            fire;
  logic [CntW-1:0] prog_n;
  logic [CntW-1:0] cnt_ext;
  logic [CntW-1:0] slot_ext;

  assign fire     = q_valid_i && (!out_vld_q || !out_stall_i);
  assign q_pop_o  = fire;
  assign cnt_ext  = CntW'(cmd_i.count);
  assign slot_ext = CntW'(cmd_i.slot);
  assign prog_n   = prog_q + CntW'(1);

  // Execute one command against the transaction state.
  always_comb begin
    active_d    = active_q;
    dir_d       = dir_q;
    addr_d      = addr_q;
    ptr_d       = ptr_q;
    total_d     = total_q;
    prog_d      = prog_q;
    start_n     = 1'b0;
    stop_n      = 1'b0;
    sendv_n     = 1'b0;
    sel_ram_n   = 1'b0;
    send_byte_n = '0;
    ack_n       = 1'b0;
    rxv_n       = 1'b0;
    rx_slot_n   = '0;
    ok_n        = 1'b0;
    fail_n      = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = IdxW'(cmd_i.slot);
    wdata       = cmd_i.data;
    raddr       = prog_q[IdxW-1:0];

    case (cmd_i.kind)
      CmdLoad: begin
        we = (slot_ext < DepthCnt);
      end
      CmdStart: begin
        active_d = 1'b1;
        dir_d    = cmd_i.rnw;
        addr_d   = cmd_i.dev_addr;
        ptr_d    = cmd_i.reg_idx;
        total_d  = (cnt_ext > DepthCnt) ? DepthCnt : cnt_ext;
        prog_d   = '0;
        start_n  = 1'b1;
      end
      CmdEvent: begin
        if (active_q) begin
          case (cmd_i.cls)
            ClsSendAddr: begin
              sendv_n     = 1'b1;
              send_byte_n = addr_q;
            end
            ClsSendAddrDir: begin
              sendv_n     = 1'b1;
              send_byte_n = addr_q + {7'd0, dir_q};
            end
            ClsSendReg: begin
              sendv_n     = 1'b1;
              send_byte_n = ptr_q;
            end
            ClsTxNext: begin
              if (dir_q) begin
                start_n = 1'b1;
              end else if (prog_q < total_q) begin
                sendv_n   = 1'b1;
                sel_ram_n = 1'b1;
                re        = 1'b1;
                prog_d    = prog_n;
              end else begin
                stop_n   = 1'b1;
                ok_n     = 1'b1;
                active_d = 1'b0;
              end
            end
            ClsRxAddrAck: begin
              ack_n = (total_q > CntW'(1));
            end
            ClsRxData: begin
              if (prog_q < DepthCnt) begin
                we        = 1'b1;
                waddr     = prog_q[IdxW-1:0];
                rxv_n     = 1'b1;
                rx_slot_n = prog_q[2:0];
                prog_d    = prog_n;
              end
              if (prog_d >= total_q || prog_d >= DepthCnt) begin
                stop_n   = 1'b1;
                ok_n     = 1'b1;
                active_d = 1'b0;
              end else begin
                ack_n = ((total_q - prog_d) > CntW'(1));
              end
            end
            ClsRxLast: begin
              if (prog_q < DepthCnt) begin
                we        = 1'b1;
                waddr     = prog_q[IdxW-1:0];
                rxv_n     = 1'b1;
                rx_slot_n = prog_q[2:0];
                prog_d    = prog_n;
              end
              stop_n   = 1'b1;
              ok_n     = 1'b1;
              active_d = 1'b0;
            end
            default: begin
              stop_n   = 1'b1;
              fail_n   = 1'b1;
              active_d = 1'b0;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // Transaction state, valid bits and result handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      dir_q     <= 1'b0;
      addr_q    <= '0;
      ptr_q     <= '0;
      total_q   <= '0;
      prog_q    <= '0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (fire) begin
        active_q <= active_d;
        dir_q    <= dir_d;
        addr_q   <= addr_d;
        ptr_q    <= ptr_d;
        total_q  <= total_d;
        prog_q   <= prog_d;
        if (we) begin
          vld_q[waddr] <= 1'b1;
        end
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      start_q     <= start_n;
      stop_q      <= stop_n;
      sendv_q     <= sendv_n;
      sel_ram_q   <= sel_ram_n;
      hit_q       <= vld_q[raddr];
      send_byte_q <= send_byte_n;
      ack_q       <= ack_n;
      rxv_q       <= rxv_n;
      rx_slot_q   <= rx_slot_n;
      rx_byte_q   <= rxv_n ? cmd_i.data : 8'd0;
      ok_q        <= ok_n;
      fail_q      <= fail_n;
      busy_q      <= active_d;
    end
  end

  i2ct_ram #(
    .Width (8),
    .Depth (BUFFER_DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (fire && we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (fire && re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Buffered data bytes come straight from the RAM read register.
  assign out_valid_o    = out_vld_q;
  assign issue_start_o  = start_q;
  assign issue_stop_o   = stop_q;
  assign send_valid_o   = sendv_q;
  assign byte_to_send_o = sel_ram_q ? (hit_q ? rdata : 8'd0) : send_byte_q;
  assign ack_next_o     = ack_q;
  assign rx_valid_o     = rxv_q;
  assign rx_slot_o      = rx_slot_q;
  assign rx_byte_o      = rx_byte_q;
  assign done_ok_o      = ok_q;
  assign done_fail_o    = fail_q;
  assign busy_res_o     = busy_q;

  a_one_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(ok_q && fail_q))
    else $error("success and failure reported together");

  a_prog_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (prog_q <= total_q))
    else $error("progress count beyond transfer count while active");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (ok_q || fail_q)) |-> (!busy_q && stop_q))
    else $error("finished transaction still busy or without STOP");

endmodule

>>> hw/rtl/i2c_master_register_transfer.sv
// Top level of the I2C master register transfer sequencer.
// Depends on i2ct_pkg, i2ct_front, i2ct_fifo, i2ct_back and i2ct_ram.
//
//   Channel | Handshake                      | Beat
//   --------+--------------------------------+---------------------------------
//   in      | in_valid_i / in_stall_o        | opcode, start, load, event fields
//   out     | out_valid_o / out_stall_i      | bus actions, rx byte, done, busy
//
// One beat per cycle in and out while neither channel stalls; every input beat yields one result beat.
// An accepted beat passes the command queue and then the result register before its result is valid.
// The two-entry command queue sets in_stall_o; the back part is stalled
// only by out_stall_i on its result register.
// Reset clears the transaction state and the buffer valid bits at once;
// there is no clearing pass, unwritten buffer bytes read as zero.
module i2c_master_register_transfer import i2ct_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = BufferDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  logic       read_not_write_i,
  input  logic [7:0] device_address_i,
  input  logic [7:0] register_index_i,
  input  logic [3:0] byte_count_i,
  input  logic [2:0] buffer_slot_i,
  input  logic [7:0] load_value_i,
  input  logic [7:0] bus_status_i,
  input  logic [7:0] received_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       issue_start_o,
  output logic       issue_stop_o,
  output logic       send_valid_o,
  output logic [7:0] byte_to_send_o,
  output logic       ack_next_o,
  output logic       rx_valid_o,
  output logic [2:0] rx_slot_o,
  output logic [7:0] rx_byte_o,
  output logic       done_ok_o,
  output logic       done_fail_o,
  output logic       busy_res_o
);

  logic q_full, q_push, q_valid, q_pop;
  cmd_t push_cmd, pop_cmd;

  // Decode incoming beats.
  i2ct_front u_front (
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .read_not_write_i (read_not_write_i),
    .device_address_i (device_address_i),
    .register_index_i (register_index_i),
    .byte_count_i     (byte_count_i),
    .buffer_slot_i    (buffer_slot_i),
    .load_value_i     (load_value_i),
    .bus_status_i     (bus_status_i),
    .received_value_i (received_value_i),
    .q_full_i         (q_full),
    .push_o           (q_push),
    .cmd_o            (push_cmd)
  );

  // Command queue between decode and execution.
  i2ct_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (pop_cmd)
  );

  // Execute commands and register results.
  i2ct_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .cmd_i          (pop_cmd),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .issue_start_o  (issue_start_o),
    .issue_stop_o   (issue_stop_o),
    .send_valid_o   (send_valid_o),
    .byte_to_send_o (byte_to_send_o),
    .ack_next_o     (ack_next_o),
    .rx_valid_o     (rx_valid_o),
    .rx_slot_o      (rx_slot_o),
    .rx_byte_o      (rx_byte_o),
    .done_ok_o      (done_ok_o),
    .done_fail_o    (done_fail_o),
    .busy_res_o     (busy_res_o)
  );

endmodule

>>> tb/sv/i2ct_transfer_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the I2C register transfer sequencer: predicts one bus action per input beat.
// It watches both channels, predicts from its own transaction state and compares in order.
// Depends on i2ct_pkg for opcodes, the status mask and the status codes.
module i2ct_transfer_checker import i2ct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel, observed.
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  opcode_i,
  input  logic        read_not_write_i,
  input  logic [7:0]  device_address_i,
  input  logic [7:0]  register_index_i,
  input  logic [3:0]  byte_count_i,
  input  logic [2:0]  buffer_slot_i,
  input  logic [7:0]  load_value_i,
  input  logic [7:0]  bus_status_i,
  input  logic [7:0]  received_value_i,
  // Result channel, observed.
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        issue_start_i,
  input  logic        issue_stop_i,
  input  logic        send_valid_i,
  input  logic [7:0]  byte_to_send_i,
  input  logic        ack_next_i,
  input  logic        rx_valid_i,
  input  logic [2:0]  rx_slot_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        done_ok_i,
  input  logic        done_fail_i,
  input  logic        busy_res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned Depth = BufferDepthDefault;

  // One bus action as the block reports it.
  typedef struct packed {
    logic       issue_start;
    logic       issue_stop;
    logic       send_valid;
    logic [7:0] byte_to_send;
    logic       ack_next;
    logic       rx_valid;
    logic [2:0] rx_slot;
    logic [7:0] rx_byte;
    logic       done_ok;
    logic       done_fail;
    logic       busy_res;
  } bus_action_t;

  // Shadow copy of the transaction state and the byte buffer.
  logic       txn_active;
  logic       txn_read;
  logic [7:0] txn_addr;
  logic [7:0] txn_reg;
  logic [3:0] txn_total;
  logic [3:0] txn_progress;
  logic [7:0] data_buf [Depth];

  bus_action_t expected_actions [$];
  bus_action_t oldest;
  int unsigned mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = expected_actions.size();

  // Ends the transaction with a STOP and a success or failure flag.
  function automatic void close_txn(input logic ok, inout bus_action_t act);
    act.issue_stop = 1'b1;
    act.done_ok    = ok;
    act.done_fail  = !ok;
    txn_active     = 1'b0;
  endfunction

  // Stores a received byte unless the buffer is already full.
  function automatic void store_rx_byte(input logic [7:0] value, inout bus_action_t act);
    if (txn_progress < Depth) begin
      data_buf[txn_progress[2:0]] = value;
      act.rx_valid = 1'b1;
      act.rx_slot  = txn_progress[2:0];
      act.rx_byte  = value;
      txn_progress = txn_progress + 4'd1;
    end
  endfunction

  // Works out the bus action of one beat and advances the shadow state.
  function automatic bus_action_t predict_bus_action(
    input logic [1:0] op,
    input logic       rnw,
    input logic [7:0] dev,
    input logic [7:0] reg_index,
    input logic [3:0] count,
    input logic [2:0] slot,
    input logic [7:0] value,
    input logic [7:0] status,
    input logic [7:0] rx
  );
    bus_action_t act;
    act = '0;
    case (op)
      OpLoad: begin
        data_buf[slot] = value;
      end
      OpStart: begin
        txn_active   = 1'b1;
        txn_read     = rnw;
        txn_addr     = dev;
        txn_reg      = reg_index;
        txn_total    = (count > Depth) ? 4'(Depth) : count;
        txn_progress = '0;
        act.issue_start = 1'b1;
      end
      OpEvent: begin
        if (txn_active) begin
          case (status & StatusMask)
            StStartSent: begin
              act.send_valid   = 1'b1;
              act.byte_to_send = txn_addr;
            end
            StRepStartSent: begin
              act.send_valid   = 1'b1;
              act.byte_to_send = txn_addr + {7'd0, txn_read};
            end
            StAddrWrAck: begin
              act.send_valid   = 1'b1;
              act.byte_to_send = txn_reg;
            end
            StDataTxAck: begin
              // A read turns around here; a write streams the buffer, then stops.
              if (txn_read) begin
                act.issue_start = 1'b1;
              end else if (txn_progress < txn_total) begin
                act.send_valid   = 1'b1;
                act.byte_to_send = data_buf[txn_progress[2:0]];
                txn_progress     = txn_progress + 4'd1;
              end else begin
                close_txn(1'b1, act);
              end
            end
            StAddrRdAck: begin
              act.ack_next = (txn_total > 4'd1);
            end
            StDataRxAck: begin
              store_rx_byte(rx, act);
              if (txn_progress >= txn_total || txn_progress >= Depth) begin
                close_txn(1'b1, act);
              end else begin
                act.ack_next = ((txn_total - txn_progress) > 4'd1);
              end
            end
            StDataRxNack: begin
              store_rx_byte(rx, act);
              close_txn(1'b1, act);
            end
            default: begin
              close_txn(1'b0, act);
            end
          endcase
        end
      end
      default: ;
    endcase
    act.busy_res = txn_active;
    return act;
  endfunction

  // Reports one field that differs from its expectation.
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Result beats are checked before the input beat of the same edge is predicted,
  // since a result never leaves in the cycle its beat is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      txn_active   = 1'b0;
      txn_read     = 1'b0;
      txn_addr     = '0;
      txn_reg      = '0;
      txn_total    = '0;
      txn_progress = '0;
      foreach (data_buf[k]) data_buf[k] = '0;
      expected_actions.delete();
      mismatches = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_actions.size() == 0) begin
          $error("result beat arrived with no beat outstanding");
          mismatches++;
        end else begin
          oldest = expected_actions.pop_front();
          check_field("issue_start", oldest.issue_start, issue_start_i);
          check_field("issue_stop", oldest.issue_stop, issue_stop_i);
          check_field("send_valid", oldest.send_valid, send_valid_i);
          check_field("byte_to_send", oldest.byte_to_send, byte_to_send_i);
          check_field("ack_next", oldest.ack_next, ack_next_i);
          check_field("rx_valid", oldest.rx_valid, rx_valid_i);
          check_field("rx_slot", oldest.rx_slot, rx_slot_i);
          check_field("rx_byte", oldest.rx_byte, rx_byte_i);
          check_field("done_ok", oldest.done_ok, done_ok_i);
          check_field("done_fail", oldest.done_fail, done_fail_i);
          check_field("busy_res", oldest.busy_res, busy_res_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_actions.push_back(predict_bus_action(opcode_i, read_not_write_i,
          device_address_i, register_index_i, byte_count_i, buffer_slot_i, load_value_i,
          bus_status_i, received_value_i));
      end
    end
  end

endmodule

>>> tb/sv/tb_i2c_master_register_transfer.sv
`timescale 1ns / 100ps
// Testbench top for the I2C register transfer sequencer: clock, reset, stimulus and verdict.
// Depends on i2ct_pkg, the block itself and i2ct_transfer_checker, which does all checking.
module tb_i2c_master_register_transfer;
  import i2ct_pkg::*;

  localparam int unsigned ClkPeriod   = 20;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned ItemTarget  = 1600;
  localparam int unsigned LongHold    = 200;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned Depth       = BufferDepthDefault;
  // The fourth opcode value is not assigned to any command.
  localparam logic [1:0]  OpUnused    = 2'd3;

  // One command beat as the sender offers it.
  typedef struct packed {
    logic [1:0] op;
    logic       rnw;
    logic [7:0] dev;
    logic [7:0] reg_index;
    logic [3:0] count;
    logic [2:0] slot;
    logic [7:0] value;
    logic [7:0] status;
    logic [7:0] rx;
  } cmd_beat_t;

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       in_valid_i       = 1'b0;
  logic       in_stall_o;
  logic [1:0] opcode_i         = '0;
  logic       read_not_write_i = 1'b0;
  logic [7:0] device_address_i = '0;
  logic [7:0] register_index_i = '0;
  logic [3:0] byte_count_i     = '0;
  logic [2:0] buffer_slot_i    = '0;
  logic [7:0] load_value_i     = '0;
  logic [7:0] bus_status_i     = '0;
  logic [7:0] received_value_i = '0;
  logic       out_valid_o;
  logic       out_stall_i      = 1'b0;
  logic       issue_start_o;
  logic       issue_stop_o;
  logic       send_valid_o;
  logic [7:0] byte_to_send_o;
  logic       ack_next_o;
  logic       rx_valid_o;
  logic [2:0] rx_slot_o;
  logic [7:0] rx_byte_o;
  logic       done_ok_o;
  logic       done_fail_o;
  logic       busy_res_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned beats_sent   = 0;
  int unsigned cycle_count  = 0;
  bit          calm         = 1'b0;
  bit          hold_request = 1'b0;
  bit          run_stall    = 1'b0;
  int unsigned run_left     = 0;

  i2c_master_register_transfer dut (.*);

  i2ct_transfer_checker checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .opcode_i        (opcode_i),
    .read_not_write_i(read_not_write_i),
    .device_address_i(device_address_i),
    .register_index_i(register_index_i),
    .byte_count_i    (byte_count_i),
    .buffer_slot_i   (buffer_slot_i),
    .load_value_i    (load_value_i),
    .bus_status_i    (bus_status_i),
    .received_value_i(received_value_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .issue_start_i   (issue_start_o),
    .issue_stop_i    (issue_stop_o),
    .send_valid_i    (send_valid_o),
    .byte_to_send_i  (byte_to_send_o),
    .ack_next_i      (ack_next_o),
    .rx_valid_i      (rx_valid_o),
    .rx_slot_i       (rx_slot_o),
    .rx_byte_i       (rx_byte_o),
    .done_ok_i       (done_ok_o),
    .done_fail_i     (done_fail_o),
    .busy_res_i      (busy_res_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Every field random, including the ones the opcode does not use.
  function automatic cmd_beat_t random_beat();
    cmd_beat_t b;
    b.op        = 2'($urandom_range(0, 3));
    b.rnw       = 1'($urandom);
    b.dev       = 8'($urandom);
    b.reg_index = 8'($urandom);
    b.count     = 4'($urandom);
    b.slot      = 3'($urandom);
    b.value     = 8'($urandom);
    b.status    = 8'($urandom);
    b.rx        = 8'($urandom);
    return b;
  endfunction

  function automatic cmd_beat_t load_beat(input logic [2:0] slot, input logic [7:0] value);
    cmd_beat_t b;
    b       = random_beat();
    b.op    = OpLoad;
    b.slot  = slot;
    b.value = value;
    return b;
  endfunction

  function automatic cmd_beat_t start_beat(input logic rnw, input logic [7:0] dev,
                                           input logic [7:0] reg_index, input logic [3:0] count);
    cmd_beat_t b;
    b           = random_beat();
    b.op        = OpStart;
    b.rnw       = rnw;
    b.dev       = dev;
    b.reg_index = reg_index;
    b.count     = count;
    return b;
  endfunction

  // The low three status bits carry noise, as on a real controller.
  function automatic cmd_beat_t event_beat(input logic [7:0] code);
    cmd_beat_t b;
    b        = random_beat();
    b.op     = OpEvent;
    b.status = (code & StatusMask) | 8'($urandom_range(0, 7));
    return b;
  endfunction

  // Offers one beat, holds it until accepted, then may idle for a while.
  task automatic send_beat(input cmd_beat_t b);
    int unsigned gap;
    @(negedge clk_i);
    opcode_i         <= b.op;
    read_not_write_i <= b.rnw;
    device_address_i <= b.dev;
    register_index_i <= b.reg_index;
    byte_count_i     <= b.count;
    buffer_slot_i    <= b.slot;
    load_value_i     <= b.value;
    bus_status_i     <= b.status;
    received_value_i <= b.rx;
    in_valid_i       <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    gap = calm ? 0 : pick_idle();
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_event_rx(input logic [7:0] code, input logic [7:0] rx);
    cmd_beat_t b;
    b    = event_beat(code);
    b.rx = rx;
    send_beat(b);
  endtask

  // One register transfer as a bus controller would report it, at times broken.
  task automatic run_transfer();
    logic [7:0]  codes [$];
    logic        rnw;
    logic [3:0]  count;
    int unsigned n;
    rnw   = 1'($urandom);
    count = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    n     = (count > Depth) ? Depth : count;
    repeat ($urandom_range(0, 8)) send_beat(load_beat(3'($urandom), 8'($urandom)));
    send_beat(start_beat(rnw, 8'($urandom), 8'($urandom), count));
    codes.push_back(StStartSent);
    codes.push_back(StAddrWrAck);
    if (rnw) begin
      codes.push_back(StDataTxAck);
      codes.push_back(StRepStartSent);
      codes.push_back(StAddrRdAck);
      if (n == 0) begin
        codes.push_back(StDataRxNack);
      end else begin
        repeat (n - 1) codes.push_back(StDataRxAck);
        codes.push_back($urandom_range(0, 1) ? StDataRxAck : StDataRxNack);
      end
    end else begin
      repeat (n + 1) codes.push_back(StDataTxAck);
      // A full write followed by a receive status runs past the end of the buffer.
      if (n == Depth && $urandom_range(0, 1) == 1) begin
        codes[codes.size() - 1] = $urandom_range(0, 1) ? StDataRxAck : StDataRxNack;
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      codes[$urandom_range(0, codes.size() - 1)] = {5'($urandom), 3'b000};
    end
    foreach (codes[i]) send_beat(event_beat(codes[i]));
  endtask

  // Result side: random stall runs, a long hold on request, none while calm.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LongHold - 1) @(negedge clk_i);
      end else if (calm) begin
        out_stall_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_stall = ($urandom_range(0, 2) == 0);
          if (run_stall) begin
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
          end else begin
            run_left = $urandom_range(1, 12);
          end
        end
        out_stall_i <= run_stall;
        run_left--;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    cmd_beat_t b;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: idle event, unused opcode, buffer extremes.
    send_beat(event_beat(StStartSent));
    b    = random_beat();
    b.op = OpUnused;
    send_beat(b);
    send_beat(load_beat(3'd7, 8'hFF));
    send_beat(load_beat(3'd0, 8'h00));

    // One-byte write through to its STOP.
    send_beat(start_beat(1'b0, 8'hFF, 8'h00, 4'd1));
    send_beat(event_beat(StStartSent));
    send_beat(event_beat(StAddrWrAck));
    send_beat(event_beat(StDataTxAck));
    send_beat(event_beat(StDataTxAck));

    // Read with an oversized count; the read address wraps to zero.
    send_beat(start_beat(1'b1, 8'hFF, 8'hFF, 4'd15));
    send_beat(event_beat(StStartSent));
    send_beat(event_beat(StAddrWrAck));
    send_beat(event_beat(StDataTxAck));
    send_beat(event_beat(StRepStartSent));
    send_beat(event_beat(StAddrRdAck));
    send_event_rx(StDataRxAck, 8'h00);
    send_event_rx(StDataRxNack, 8'hFF);

    // Load while busy, then a start that replaces the running transfer.
    send_beat(start_beat(1'b0, 8'h00, 8'hAA, 4'd0));
    send_beat(load_beat(3'd3, 8'h5A));
    send_beat(start_beat(1'b1, 8'h42, 8'h10, 4'd1));
    send_beat(event_beat(StAddrRdAck));
    send_event_rx(StDataRxAck, 8'hC3);

    // Error statuses abort with a failure.
    send_beat(start_beat(1'b0, 8'h20, 8'h01, 4'd2));
    send_beat(event_beat(StAddrWrNack));
    send_beat(start_beat(1'b1, 8'h30, 8'h02, 4'd8));
    send_beat(event_beat(8'hF8));

    // Random part; the long hold on the result side comes first.
    hold_request = 1'b1;
    while (beats_sent < ItemTarget) begin
      calm = (beats_sent >= 800 && beats_sent < 1000);
      if ($urandom_range(0, 9) < 7) begin
        run_transfer();
      end else begin
        repeat ($urandom_range(1, 4)) send_beat(random_beat());
      end
    end
    calm = 1'b0;

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
